### hdl/gbs_pkg.sv
package gbs_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned SLOT_W     = 6;

  // Overlap threshold after reset (0.5 with 16 fraction bits)
  localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

  // One candidate box
  typedef struct packed {
    logic [IN_COORD_W-1:0] left;
    logic [IN_COORD_W-1:0] top;
    logic [IN_COORD_W-1:0] right;
    logic [IN_COORD_W-1:0] bottom;
    logic                  last_box;
  } box_t;

  // One keep decision
  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] kept_slot;
    logic              table_full;
    logic              set_end;
  } decision_t;

  typedef logic [THR_W-1:0] thr_t;

  // Sequencer to compare unit
  typedef struct packed {
    logic prep;   // latch candidate area, clear suppress flag
    logic issue;  // a table read was issued this cycle
  } iou_ctl_t;

  // Compare unit to sequencer
  typedef struct packed {
    logic busy;   // compares still in flight
    logic hit;    // some kept box overlaps above threshold
  } iou_stat_t;

endpackage

### hdl/gbs_stream_if.sv
interface gbs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/greedy_box_suppression_unit.sv
// Flow: each box word is compared against the N boxes kept so far in the set (at most
//   MAX_KEPT), then its decision word is raised; a new box word is taken only once
//   that decision word has been loaded into the output register. The table is read
//   one entry per cycle into a five-stage compare pipeline.
// Reset: kept count cleared, threshold back to 0.5, no decision pending. Table
//   contents are not cleared; only entries below the kept count are ever read.
module greedy_box_suppression_unit #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  gbs_stream_if.sink   box,
  gbs_stream_if.source decision,
  gbs_stream_if.sink   cfg
);
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned BW   = 4 * CW;
  localparam int unsigned AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CNTW = $clog2(MAX_KEPT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t                 state;
  logic [CNTW-1:0]        count;
  logic [CNTW-1:0]        idx;
  gbs_pkg::thr_t          thr;
  logic [BW-1:0]          cand;
  logic                   last;
  gbs_pkg::decision_t     res;
  logic                   res_valid;
  logic [BW-1:0]          kept_word;
  gbs_pkg::iou_ctl_t      ctl;
  gbs_pkg::iou_stat_t     stat;
  logic                   fire;
  logic                   keep_c;
  logic                   room;
  logic                   ram_we;

  // Handshakes
  assign box.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign decision.valid = res_valid;
  assign decision.data  = res;

  // Sequencer to compare unit
  assign ctl.prep  = (state == ST_PREP);
  assign ctl.issue = (state == ST_SCAN) && (idx != count);

  // Decision and table write
  assign fire   = (state == ST_RESULT) && (!res_valid || decision.ready);
  assign keep_c = !stat.hit;
  assign room   = (count < CNTW'(MAX_KEPT));
  assign ram_we = fire && keep_c && room;

  gbs_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_KEPT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (cand),
    .raddr (idx[AW-1:0]),
    .rdata (kept_word)
  );

  gbs_iou_unit #(
    .CW (CW)
  ) u_iou (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cand (cand),
    .kept (kept_word),
    .thr  (thr),
    .stat (stat)
  );

  // Sequencer, kept count, threshold and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      thr       <= gbs_pkg::THR_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        thr <= cfg.data;
      end
      // new word loads, otherwise a taken word clears
      if (fire) begin
        res_valid <= 1'b1;
      end else if (decision.valid && decision.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (box.valid) begin
            cand  <= {CW'(box.data.left), CW'(box.data.top),
                      CW'(box.data.right), CW'(box.data.bottom)};
            last  <= box.data.last_box;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          idx   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx != count) begin
            idx <= idx + CNTW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (fire) begin
            res.keep       <= keep_c;
            res.kept_slot  <= (keep_c && room) ? gbs_pkg::SLOT_W'(count) : '0;
            res.table_full <= keep_c && !room;
            res.set_end    <= last;
            if (last) begin
              count <= '0;
            end else if (keep_c && room) begin
              count <= count + CNTW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst) ram_we |-> (count < CNTW'(MAX_KEPT)))
    else $error("table write with no room");
  assert property (@(posedge clk) disable iff (rst) count <= CNTW'(MAX_KEPT))
    else $error("kept count beyond table depth");
  assert property (@(posedge clk) disable iff (rst) ctl.issue |-> (idx < count))
    else $error("table read past kept entries");
  assert property (@(posedge clk) disable iff (rst) box.ready |-> !stat.busy)
    else $error("new box taken while compares in flight");
  assert property (@(posedge clk) disable iff (rst)
      $rose(decision.valid) |-> $past(state == ST_RESULT))
    else $error("decision raised outside result step");
endmodule

### hdl/gbs_ram.sv
module gbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/gbs_iou_unit.sv
module gbs_iou_unit #(
  parameter int unsigned CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gbs_pkg::iou_ctl_t      ctl,
  input  logic [4*CW-1:0]        cand,
  input  logic [4*CW-1:0]        kept,
  input  gbs_pkg::thr_t          thr,
  output gbs_pkg::iou_stat_t     stat
);
  localparam int unsigned AW = 2 * CW;           // area width
  localparam int unsigned UW = AW + 1;           // union width
  localparam int unsigned UL = (UW + 1) / 2;     // low slice of union
  localparam int unsigned UH = UW - UL;          // high slice of union
  localparam int unsigned TW = gbs_pkg::THR_W;
  localparam int unsigned RW = UW + TW;          // compare width

  function automatic logic [CW-1:0] span(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    span = (hi >= lo) ? hi - lo : '0;
  endfunction

  logic [CW-1:0] cx0, cy0, cx1, cy1;
  logic [CW-1:0] kx0, ky0, kx1, ky1;
  logic [CW-1:0] ix0, iy0, ix1, iy1;
  logic          v1, v2, v3, v4, v5;
  logic [CW-1:0] iw, ih, kw, kh;
  logic [AW-1:0] carea, karea, inter, inter3, inter4;
  logic [UW-1:0] uni;
  logic [UL+TW-1:0] plo;
  logic [UH+TW-1:0] phi;
  logic [RW-1:0] lhs, rhs;
  logic          hit;

  assign {cx0, cy0, cx1, cy1} = cand;
  assign {kx0, ky0, kx1, ky1} = kept;

  // Intersection corners
  assign ix0 = (cx0 > kx0) ? cx0 : kx0;
  assign iy0 = (cy0 > ky0) ? cy0 : ky0;
  assign ix1 = (cx1 < kx1) ? cx1 : kx1;
  assign iy1 = (cy1 < ky1) ? cy1 : ky1;

  // Final compare: inter * 2^16 > thr * union
  assign lhs = RW'({inter4, {TW{1'b0}}});
  assign rhs = (RW'(phi) << UL) + RW'(plo);

  // Compare pipeline: spans, products, union, split threshold product, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (ctl.prep) begin
        hit <= 1'b0;
      end else if (v5 && (lhs > rhs)) begin
        hit <= 1'b1;
      end
    end
    // candidate area, once per item
    if (ctl.prep) begin
      carea <= AW'(span(cx0, cx1)) * AW'(span(cy0, cy1));
    end
    // stage 1: table word arrives
    iw <= span(ix0, ix1);
    ih <= span(iy0, iy1);
    kw <= span(kx0, kx1);
    kh <= span(ky0, ky1);
    // stage 2: areas
    inter <= AW'(iw) * AW'(ih);
    karea <= AW'(kw) * AW'(kh);
    // stage 3: union never goes negative, inter is within both areas
    uni    <= UW'(carea) + UW'(karea) - UW'(inter);
    inter3 <= inter;
    // stage 4: threshold product in two slices
    plo    <= (UL+TW)'(uni[UL-1:0]) * (UL+TW)'(thr);
    phi    <= (UH+TW)'(uni[UW-1:UL]) * (UH+TW)'(thr);
    inter4 <= inter3;
  end

  assign stat.busy = v1 | v2 | v3 | v4 | v5;
  assign stat.hit  = hit;
endmodule

### tb/gbs_checker.sv
`timescale 1ns / 100ps

// Watches the box, decision and threshold channels, keeps its own copy of
// the kept-box table and checks every decision word in order.
module gbs_checker #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic        clk,
  input  logic        rst,
  gbs_stream_if       box,
  gbs_stream_if       decision,
  gbs_stream_if       cfg,
  output int unsigned errors,
  output int unsigned pending
);

  // Threshold and kept-box table as the block should hold them
  gbs_pkg::thr_t      cur_thr;
  gbs_pkg::box_t      kept_tab [MAX_KEPT];
  int unsigned        kept_n;

  // Decisions owed by the block, oldest first
  gbs_pkg::decision_t due [$];
  gbs_pkg::decision_t want;
  gbs_pkg::decision_t got;
  int unsigned        mismatches = 0;
  int unsigned        words_seen;

  task automatic note_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] owed);
    $display("mismatch at decision %0d: %s got %0h expected %0h",
             words_seen, what, seen, owed);
    mismatches++;
  endtask

  // Side length, zero when the edge is inverted
  function automatic longint unsigned span_len(input logic [gbs_pkg::IN_COORD_W-1:0] lo,
                                               input logic [gbs_pkg::IN_COORD_W-1:0] hi);
    return (hi >= lo) ? (64'(hi) - 64'(lo)) : 64'd0;
  endfunction

  // intersection * 2^16 > threshold * union, all exact in 64 bits
  function automatic bit exceeds_thr(input gbs_pkg::box_t a, input gbs_pkg::box_t b);
    logic [gbs_pkg::IN_COORD_W-1:0] ix0, iy0, ix1, iy1;
    longint unsigned                inter, area_a, area_b, uni;
    ix0    = (a.left > b.left) ? a.left : b.left;
    iy0    = (a.top > b.top) ? a.top : b.top;
    ix1    = (a.right < b.right) ? a.right : b.right;
    iy1    = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter  = span_len(ix0, ix1) * span_len(iy0, iy1);
    area_a = span_len(a.left, a.right) * span_len(a.top, a.bottom);
    area_b = span_len(b.left, b.right) * span_len(b.top, b.bottom);
    uni    = area_a + area_b - inter;
    return (inter << 16) > (uni * 64'(cur_thr));
  endfunction

  // Decide one candidate and update the table
  function automatic gbs_pkg::decision_t judge_box(input gbs_pkg::box_t cand);
    gbs_pkg::decision_t d;
    bit                 hit;
    hit = 1'b0;
    for (int unsigned i = 0; i < kept_n; i++) begin
      if (exceeds_thr(cand, kept_tab[i])) hit = 1'b1;
    end
    d = '0;
    d.set_end = cand.last_box;
    if (!hit) begin
      d.keep = 1'b1;
      if (kept_n < MAX_KEPT) begin
        kept_tab[kept_n] = cand;
        d.kept_slot      = gbs_pkg::SLOT_W'(kept_n);
        kept_n++;
      end else begin
        d.table_full = 1'b1;
      end
    end
    if (cand.last_box) kept_n = 0;
    return d;
  endfunction

  // Decision words are matched before new boxes are queued
  always @(posedge clk) begin
    if (rst) begin
      cur_thr    = gbs_pkg::THR_RESET;
      kept_n     = 0;
      words_seen = 0;
      due.delete();
    end else begin
      if (decision.valid && decision.ready) begin
        words_seen++;
        got = decision.data;
        if (due.size() == 0) begin
          note_mismatch("decision word with none expected", 32'(got), 32'd0);
        end else begin
          want = due.pop_front();
          if (got.keep !== want.keep)
            note_mismatch("keep", 32'(got.keep), 32'(want.keep));
          if (got.kept_slot !== want.kept_slot)
            note_mismatch("kept_slot", 32'(got.kept_slot), 32'(want.kept_slot));
          if (got.table_full !== want.table_full)
            note_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
          if (got.set_end !== want.set_end)
            note_mismatch("set_end", 32'(got.set_end), 32'(want.set_end));
        end
      end
      if (cfg.valid && cfg.ready) cur_thr = cfg.data;
      if (box.valid && box.ready) due = {due, judge_box(box.data)};
    end
    errors  <= mismatches;
    pending <= due.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MAX_KEPT    = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 250;

  typedef enum int unsigned {STYLE_GRID, STYLE_CLUSTER, STYLE_MIXED} set_style_t;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned errors;
  int unsigned pending;

  // Idle control shared by the sender and the receiver
  bit          no_idle = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;

  // Anchor of clustered boxes and a short history for repeats
  logic [gbs_pkg::IN_COORD_W-1:0] cx, cy;
  gbs_pkg::box_t                  recent [$];

  gbs_stream_if #(.T(gbs_pkg::box_t))      box_if ();
  gbs_stream_if #(.T(gbs_pkg::decision_t)) dec_if ();
  gbs_stream_if #(.T(gbs_pkg::thr_t))      cfg_if ();

  greedy_box_suppression_unit #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (gbs_pkg::IN_COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .box      (box_if),
    .decision (dec_if),
    .cfg      (cfg_if)
  );

  gbs_checker #(
    .MAX_KEPT (MAX_KEPT)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .box      (box_if),
    .decision (dec_if),
    .cfg      (cfg_if),
    .errors   (errors),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  function automatic gbs_pkg::box_t corners(input logic [15:0] l, input logic [15:0] t,
                                            input logic [15:0] r, input logic [15:0] b,
                                            input logic last);
    gbs_pkg::box_t c;
    c.left     = l;
    c.top      = t;
    c.right    = r;
    c.bottom   = b;
    c.last_box = last;
    return c;
  endfunction

  // Either fully random corners or a small box placed anywhere
  function automatic gbs_pkg::box_t any_box();
    gbs_pkg::box_t c;
    if ($urandom_range(1) == 0) begin
      c = corners(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    end else begin
      c.left   = 16'($urandom_range(0, 65000));
      c.top    = 16'($urandom_range(0, 65000));
      c.right  = c.left + 16'($urandom_range(0, 500));
      c.bottom = c.top + 16'($urandom_range(0, 500));
      c.last_box = 1'b0;
    end
    return c;
  endfunction

  // Disjoint boxes, one per 4096-wide cell, so the table fills up
  function automatic gbs_pkg::box_t grid_box(input int unsigned idx);
    gbs_pkg::box_t c;
    c.left     = 16'((idx % 16) * 4096 + $urandom_range(0, 1000));
    c.top      = 16'((idx / 16) * 4096 + $urandom_range(0, 1000));
    c.right    = c.left + 16'($urandom_range(1, 3000));
    c.bottom   = c.top + 16'($urandom_range(1, 3000));
    c.last_box = 1'b0;
    return c;
  endfunction

  // Boxes near one anchor: overlaps land around every threshold
  function automatic gbs_pkg::box_t cluster_box();
    gbs_pkg::box_t c;
    c.left     = cx + 16'($urandom_range(0, 150));
    c.top      = cy + 16'($urandom_range(0, 150));
    c.right    = c.left + 16'($urandom_range(0, 300));
    c.bottom   = c.top + 16'($urandom_range(0, 300));
    c.last_box = 1'b0;
    return c;
  endfunction

  function automatic gbs_pkg::box_t repeat_box();
    if (recent.size() == 0) return any_box();
    return recent[$urandom_range(recent.size() - 1)];
  endfunction

  function automatic gbs_pkg::thr_t phase_thr(input int unsigned phase);
    unique case (phase)
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return gbs_pkg::THR_RESET;
      3: return 16'h0001;
      5: return 16'h4000;
      7: return 16'hB333;
      default: return gbs_pkg::thr_t'($urandom);
    endcase
  endfunction

  // Offer one box word, with random idle cycles ahead of it
  task automatic offer_box(input gbs_pkg::box_t b);
    if (!no_idle) begin
      while ($urandom_range(99) < 29) begin
        box_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    box_if.valid <= 1'b1;
    box_if.data  <= b;
    do @(posedge clk); while (!box_if.ready);
    recent = {recent, b};
    if (recent.size() > 16) void'(recent.pop_front());
  endtask

  // Stop offering and wait until every decision has come back
  task automatic finish_pending();
    box_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_thr(input gbs_pkg::thr_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    // full frame, then the same box again: overlap of one
    offer_box(corners(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    offer_box(corners(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    // point box twice: zero union against itself
    offer_box(corners(16'd100, 16'd100, 16'd100, 16'd100, 1'b0));
    offer_box(corners(16'd100, 16'd100, 16'd100, 16'd100, 1'b0));
    // inverted in x, then in both axes
    offer_box(corners(16'd500, 16'd0, 16'd100, 16'hFFFF, 1'b0));
    offer_box(corners(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    // small box, then one touching its edge only
    offer_box(corners(16'd0, 16'd0, 16'd10, 16'd10, 1'b0));
    offer_box(corners(16'd10, 16'd0, 16'd20, 16'd10, 1'b0));
    // right half of the frame, just under one half; closes the set
    offer_box(corners(16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    // overlap of exactly one half is not above the threshold
    offer_box(corners(16'd0, 16'd0, 16'd2, 16'd1, 1'b0));
    offer_box(corners(16'd0, 16'd0, 16'd1, 16'd1, 1'b0));
    offer_box(corners(16'd0, 16'd0, 16'd2, 16'd1, 1'b1));
    // table emptied: same box lands in slot zero again
    offer_box(corners(16'd0, 16'd0, 16'd1, 16'd1, 1'b1));
    offer_box(corners(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));
  endtask

  // One set of boxes; now and then the set is left open
  task automatic run_random_set(output int unsigned n);
    set_style_t    style;
    int unsigned   pick;
    bit            open_set;
    gbs_pkg::box_t b;
    pick = $urandom_range(99);
    if (pick < 20) begin
      style = STYLE_GRID;
      n     = $urandom_range(60, 72);
    end else if (pick < 70) begin
      style = STYLE_CLUSTER;
      n     = $urandom_range(1, 40);
    end else begin
      style = STYLE_MIXED;
      n     = $urandom_range(1, 20);
    end
    cx       = 16'($urandom_range(0, 60000));
    cy       = 16'($urandom_range(0, 60000));
    open_set = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      unique case (style)
        STYLE_GRID:    b = (pick < 90) ? grid_box(i) : any_box();
        STYLE_CLUSTER: b = (pick < 75) ? cluster_box() :
                           (pick < 90) ? repeat_box() : any_box();
        default:       b = (pick < 80) ? any_box() : repeat_box();
      endcase
      b.last_box = (i == n - 1) && !open_set;
      offer_box(b);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    dec_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        dec_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        dec_if.ready <= no_idle || ($urandom_range(99) >= 29);
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((box_if.valid && box_if.ready) || (dec_if.valid && dec_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned n;
    rst          <= 1'b1;
    box_if.valid <= 1'b0;
    box_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed boxes run at the reset threshold
    run_directed();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      finish_pending();
      write_thr(phase_thr(phase));
      no_idle = (phase == 5);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        // output held off while boxes keep coming
        if (phase == 2 && sent >= 100 && holds_asked == 0) holds_asked++;
        run_random_set(n);
        sent += n;
      end
    end

    finish_pending();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
